/* rtl/assert_macros.svh */
// Assertion macros shared by the GPIO controller RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/gcpl_pkg.sv */
// Types and constants of the per-line GPIO controller.
// No dependencies; used by the register file, the top level and the testbench.
package gcpl_pkg;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [7:0] ADDR_MODE      = 8'h00;
  localparam logic [7:0] ADDR_STATUS_S  = 8'h84;
  localparam logic [7:0] ADDR_RAW_S     = 8'h88;
  localparam logic [7:0] ADDR_PORT      = 8'h8c;
  localparam logic [7:0] ADDR_STATUS_NS = 8'ha4;
  localparam logic [7:0] ADDR_RAW_NS    = 8'ha8;

  localparam logic [9:0] KEEP_BITS = 10'h2ff;
  localparam int         EOI_BIT   = 8;

  typedef struct packed {
    logic both;
    logic eoi;
    logic debounce;
    logic pol;
    logic edge_mode;
    logic imask;
    logic ien;
    logic src_sel;
    logic oe;
    logic data;
  } line_word_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  address;
    logic [31:0] write_data;
    logic [31:0] pad_levels;
  } in_word_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [31:0] drive_values;
    logic [31:0] drive_enables;
    logic        irq;
  } out_word_t;

  typedef struct packed {
    logic     commit;
    in_word_t word;
  } cmd_t;

  // Bit n set for every implemented line.
  function automatic logic [31:0] line_mask(input int lines);
    logic [32:0] span;
    span = (33'd1 << lines) - 33'd1;
    return span[31:0];
  endfunction

  // Raw interrupt status from gathered control vectors and the pad sample.
  function automatic logic [31:0] raw_status(input logic [31:0] en,
                                             input logic [31:0] edg,
                                             input logic [31:0] pol,
                                             input logic [31:0] pads,
                                             input logic [31:0] latched);
    logic [31:0] lvl;
    lvl = ~(pads ^ pol);
    return ((edg & latched) | (~edg & lvl)) & en;
  endfunction

endpackage

/* rtl/gcpl_chan.sv */
// Valid/ready channel carrying one word of type T.
// Depends on nothing; the payload types come from gcpl_pkg.
interface gcpl_chan #(parameter type T = logic [31:0]);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/gpio_controller_per_line_words.sv */
// GPIO controller with one control word per line.
// Inputs: in_chan carries one word per operation: a bus read, a bus write,
//   or a pad sample tick (operation, address, write_data, pad_levels).
// Outputs: out_chan returns exactly one word per accepted input word:
//   read_data (zero unless a read), drive_values, drive_enables and irq,
//   the drive fields and irq showing the state after that operation.
// Path: an accepted word waits in the input register, then moves to the
//   result register, where out_chan.valid rises; a stall can hold it.
// Throughput: one word per cycle while out_chan.ready stays high, set by
//   the single state-update stage; every register update completes in the
//   cycle the word leaves the input register.
// Stall: when out_chan.ready is low the result word holds and the input
//   register holds; in_chan.ready still stays high while the input
//   register is empty, so one more word can wait.
// Reset: rst_n (synchronous, active low) clears every line word, the
//   latched edge status, the last pad sample and the mode word, and
//   empties both pipeline registers. Depends on gcpl_pkg, gcpl_chan,
//   gcpl_regs and assert_macros.svh.
`include "assert_macros.svh"
module gpio_controller_per_line_words #(
  parameter int LINES = 32
) (
  input logic    clk,
  input logic    rst_n,
  gcpl_chan.sink   in_chan,
  gcpl_chan.source out_chan
);
  import gcpl_pkg::*;

  localparam logic [31:0] LMASK = line_mask(LINES);

  logic      in_vld_r;
  in_word_t  in_word_r;
  logic      out_vld_r;
  out_word_t out_word_r;
  logic      advance, in_take;
  cmd_t      cmd;
  out_word_t res;

  // Advance the result register when it is empty or being taken.
  assign advance       = !out_vld_r || out_chan.ready;
  assign in_chan.ready = !in_vld_r || advance;
  assign in_take       = in_chan.valid && in_chan.ready;

  // Commit a word to the register file only when its result can be stored.
  assign cmd.commit = in_vld_r && advance;
  assign cmd.word   = in_word_r;

  gcpl_regs #(.LINES(LINES)) u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_chan.ready) in_vld_r <= in_chan.valid;
      if (advance) out_vld_r <= in_vld_r;
    end
  end

  // Payload registers: load only, no reset.
  always_ff @(posedge clk) begin
    if (in_take) in_word_r <= in_chan.data;
    if (cmd.commit) out_word_r <= res;
  end

  assign out_chan.valid = out_vld_r;
  assign out_chan.data  = out_word_r;

  `ASSERT_IMPLY(a_ready_when_free, clk, rst_n, !out_vld_r, in_chan.ready)
  `ASSERT_NEXT(a_commit_shows, clk, rst_n, cmd.commit, out_vld_r)
  `ASSERT_IMPLY(a_drive_lines, clk, rst_n, out_vld_r,
                ((out_word_r.drive_values | out_word_r.drive_enables) & ~LMASK) == '0)

endmodule

/* rtl/gcpl_regs.sv */
// Register file and per-line interrupt logic of the GPIO controller.
// Depends on gcpl_pkg and assert_macros.svh.
`include "assert_macros.svh"
module gcpl_regs #(
  parameter int LINES = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  gcpl_pkg::cmd_t      cmd,
  output gcpl_pkg::out_word_t res
);
  import gcpl_pkg::*;

  localparam int          LIDX_W = (LINES > 1) ? $clog2(LINES) : 1;
  localparam logic [31:0] LMASK  = line_mask(LINES);

  line_word_t  ctl_r   [LINES];
  line_word_t  ctl_nxt [LINES];
  logic [31:0] prev_pads_r, prev_pads_nxt;
  logic [31:0] edge_r, edge_nxt;
  logic [31:0] mode_r, mode_nxt;

  logic [31:0] en_c, edg_c, pol_c, msk_c, both_c;
  logic [31:0] en_n, edg_n, pol_n, msk_n, dat_n, oe_n;
  logic [31:0] raw_c, masked_c, raw_n;
  logic [31:0] now, rise, fall, pick;
  logic [1:0]  op;
  logic [7:0]  addr;
  logic [5:0]  idx, line_num;
  logic        line_range, line_hit, secure;
  logic [LIDX_W-1:0] lsel;

  // Gather current control bits per line.
  always_comb begin
    en_c = '0; edg_c = '0; pol_c = '0; msk_c = '0; both_c = '0;
    for (int n = 0; n < LINES; n++) begin
      en_c[n]   = ctl_r[n].ien;
      edg_c[n]  = ctl_r[n].edge_mode;
      pol_c[n]  = ctl_r[n].pol;
      msk_c[n]  = ctl_r[n].imask;
      both_c[n] = ctl_r[n].both;
    end
  end

  always_comb begin
    raw_c    = raw_status(en_c, edg_c, pol_c, prev_pads_r, edge_r) & LMASK;
    masked_c = raw_c & ~msk_c;
    secure   = (mode_r != '0);
  end

  // Address decode: low two bits ignored, line words at 4*(n+1).
  always_comb begin
    op         = cmd.word.operation;
    addr       = {cmd.word.address[7:2], 2'b00};
    idx        = cmd.word.address[7:2];
    line_range = idx inside {[6'd1:6'd32]};
    line_num   = idx - 6'd1;
    line_hit   = line_range && ({1'b0, line_num} < 7'(LINES));
    lsel       = line_num[LIDX_W-1:0];
  end

  // Next state.
  always_comb begin
    ctl_nxt       = ctl_r;
    edge_nxt      = edge_r;
    prev_pads_nxt = prev_pads_r;
    mode_nxt      = mode_r;
    now           = cmd.word.pad_levels & LMASK;
    rise          = ~prev_pads_r & now;
    fall          = prev_pads_r & ~now;
    pick          = (both_c & (rise | fall)) | (~both_c & ((pol_c & rise) | (~pol_c & fall)));
    if (cmd.commit) begin
      case (op)
        OP_WRITE: begin
          if (line_hit) begin
            ctl_nxt[lsel] = line_word_t'(cmd.word.write_data[9:0] & KEEP_BITS);
            if (cmd.word.write_data[EOI_BIT]) edge_nxt[line_num[4:0]] = 1'b0;
          end else if (!line_range && addr == ADDR_MODE) begin
            mode_nxt = cmd.word.write_data;
          end
        end
        OP_TICK: begin
          edge_nxt      = edge_r | (pick & en_c & edg_c & LMASK);
          prev_pads_nxt = now;
        end
        default: ;
      endcase
    end
  end

  // Result fields: read data from the old state, drive and irq from the new.
  always_comb begin
    en_n = '0; edg_n = '0; pol_n = '0; msk_n = '0; dat_n = '0; oe_n = '0;
    for (int n = 0; n < LINES; n++) begin
      en_n[n]  = ctl_nxt[n].ien;
      edg_n[n] = ctl_nxt[n].edge_mode;
      pol_n[n] = ctl_nxt[n].pol;
      msk_n[n] = ctl_nxt[n].imask;
      dat_n[n] = ctl_nxt[n].data;
      oe_n[n]  = ctl_nxt[n].oe;
    end
    raw_n = raw_status(en_n, edg_n, pol_n, prev_pads_nxt, edge_nxt) & LMASK;

    res.read_data = '0;
    if (cmd.commit && op == OP_READ) begin
      if (line_range) begin
        if (line_hit) res.read_data = {22'd0, ctl_r[lsel]};
      end else begin
        case (addr)
          ADDR_MODE:      res.read_data = mode_r;
          ADDR_STATUS_S:  res.read_data = secure ? masked_c : '0;
          ADDR_RAW_S:     res.read_data = secure ? raw_c : '0;
          ADDR_PORT:      res.read_data = prev_pads_r;
          ADDR_STATUS_NS: res.read_data = secure ? '0 : masked_c;
          ADDR_RAW_NS:    res.read_data = secure ? '0 : raw_c;
          default:        res.read_data = '0;
        endcase
      end
    end
    res.drive_values  = dat_n;
    res.drive_enables = oe_n;
    res.irq           = |(raw_n & ~msk_n);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < LINES; n++) ctl_r[n] <= '0;
      prev_pads_r <= '0;
      edge_r      <= '0;
      mode_r      <= '0;
    end else begin
      ctl_r       <= ctl_nxt;
      prev_pads_r <= prev_pads_nxt;
      edge_r      <= edge_nxt;
      mode_r      <= mode_nxt;
    end
  end

  `ASSERT_NEXT(a_tick_sample, clk, rst_n, cmd.commit && op == OP_TICK, prev_pads_r == $past(cmd.word.pad_levels & LMASK))
  `ASSERT_IMPLY(a_rd_zero, clk, rst_n, cmd.commit == 1'b0 || op != OP_READ, res.read_data == '0)
  `ASSERT_IMPLY(a_edge_lines, clk, rst_n, 1'b1, (edge_r & ~LMASK) == '0)

endmodule

/* sim/gpio_controller_per_line_words_tb.sv */
// Self-checking testbench for gpio_controller_per_line_words: bus reads, writes and pad ticks
// are checked word by word against a predictor kept in this module.
// Depends on gcpl_pkg, gcpl_chan and the controller RTL.
module gpio_controller_per_line_words_tb;
  import gcpl_pkg::*;

  localparam int TB_LINES    = 32;
  localparam int CYCLE_LIMIT = 60000;
  localparam int HOLD_AT     = 300;   // input words accepted before the long output hold
  localparam int HOLD_LEN    = 80;    // cycles of the long output hold
  localparam int TAIL_CYCLES = 12;

  // Bit positions inside a line control word
  localparam int B_DATA = 0;
  localparam int B_OE   = 1;
  localparam int B_IEN  = 3;
  localparam int B_MASK = 4;
  localparam int B_EDGE = 5;
  localparam int B_POL  = 6;
  localparam int B_BOTH = 9;

  localparam logic [1:0] OP_NONE = 2'd3;   // unused operation code

  logic clk = 1'b0;
  logic rst_n;

  gcpl_chan #(.T(in_word_t))  in_ch ();
  gcpl_chan #(.T(out_word_t)) out_ch ();

  gpio_controller_per_line_words #(.LINES(TB_LINES)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  // Free-running clock, period 4
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: one copy of everything the controller remembers
  logic [9:0]  line_ctl [TB_LINES];
  logic [31:0] last_pads;
  logic [31:0] edge_latch;
  logic [31:0] mode_word;
  logic [31:0] impl_lines;

  in_word_t  pending_words [$];   // words waiting for the driver
  out_word_t expected_outs [$];   // predicted results, oldest first

  int errors = 0;
  int words_in = 0;      // input words accepted so far
  int cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  // Collect one control bit from every implemented line into a vector
  function automatic logic [31:0] collect_bit(int pos);
    logic [31:0] v;
    v = '0;
    for (int n = 0; n < TB_LINES; n++)
      if (line_ctl[n][pos]) v[n] = 1'b1;
    return v;
  endfunction

  function automatic logic [31:0] raw_irq_vec();
    logic [31:0] edg;
    logic [31:0] lvl;
    edg = collect_bit(B_EDGE);
    // Level lines are active while the last sample matches the polarity
    lvl = ~(last_pads ^ collect_bit(B_POL));
    return ((edg & edge_latch) | (~edg & lvl)) & collect_bit(B_IEN) & impl_lines;
  endfunction

  function automatic logic [31:0] masked_irq_vec();
    return raw_irq_vec() & ~collect_bit(B_MASK);
  endfunction

  function automatic logic [31:0] reg_read(logic [7:0] addr);
    logic [5:0]  idx;
    logic        secure;
    logic [31:0] val;
    idx    = addr[7:2];
    secure = (mode_word != 32'd0);
    val    = '0;
    if (idx >= 6'd1 && idx <= 6'd32) begin
      if (int'(idx) - 1 < TB_LINES) val = {22'd0, line_ctl[idx - 6'd1]};
    end else begin
      case (addr)
        ADDR_MODE:      val = mode_word;
        ADDR_STATUS_S:  val = secure ? masked_irq_vec() : 32'd0;
        ADDR_RAW_S:     val = secure ? raw_irq_vec() : 32'd0;
        ADDR_PORT:      val = last_pads;
        ADDR_STATUS_NS: val = secure ? 32'd0 : masked_irq_vec();
        ADDR_RAW_NS:    val = secure ? 32'd0 : raw_irq_vec();
        default:        val = '0;
      endcase
    end
    return val;
  endfunction

  function automatic void reg_write(logic [7:0] addr, logic [31:0] data);
    logic [5:0] idx;
    int         n;
    idx = addr[7:2];
    if (idx >= 6'd1 && idx <= 6'd32) begin
      n = int'(idx) - 1;
      if (n < TB_LINES) begin
        line_ctl[n] = data[9:0] & KEEP_BITS;
        // End of interrupt: drop this line's latched edge
        if (data[EOI_BIT]) edge_latch[n] = 1'b0;
      end
    end else if (addr == ADDR_MODE) begin
      mode_word = data;
    end
  endfunction

  function automatic void pad_tick(logic [31:0] pads);
    logic [31:0] now;
    logic [31:0] rise;
    logic [31:0] fall;
    logic [31:0] pol;
    logic [31:0] both;
    logic [31:0] pick;
    now  = pads & impl_lines;
    rise = ~last_pads & now;
    fall = last_pads & ~now;
    pol  = collect_bit(B_POL);
    both = collect_bit(B_BOTH);
    // Both-edge lines take any transition, the rest follow polarity
    pick = (both & (rise | fall)) | (~both & ((pol & rise) | (~pol & fall)));
    edge_latch |= pick & collect_bit(B_IEN) & collect_bit(B_EDGE) & impl_lines;
    last_pads = now;
  endfunction

  // Advance the predictor by one accepted word and return its result
  function automatic out_word_t apply_word(in_word_t w);
    out_word_t   r;
    logic [7:0]  addr;
    addr = {w.address[7:2], 2'b00};
    r = '0;
    case (w.operation)
      OP_READ:  r.read_data = reg_read(addr);
      OP_WRITE: reg_write(addr, w.write_data);
      OP_TICK:  pad_tick(w.pad_levels);
      default:  ;
    endcase
    r.drive_values  = collect_bit(B_DATA);
    r.drive_enables = collect_bit(B_OE);
    r.irq           = (masked_irq_vec() != 32'd0);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h (result after %0d words in)",
             what, got, want, words_in);
    errors++;
  endtask

  // Idle percentages per phase: sender light / receiver heavy, then swapped, then none
  function automatic int tx_idle_pct(int n);
    if (n < 260) return 25;
    if (n < 520) return 72;
    return 0;
  endfunction

  function automatic int rx_idle_pct(int n);
    if (n < 260) return 72;
    if (n < 520) return 25;
    return 0;
  endfunction

  task automatic queue_word(logic [1:0] op, logic [7:0] addr, logic [31:0] data,
                            logic [31:0] pads);
    in_word_t w;
    w.operation  = op;
    w.address    = addr;
    w.write_data = data;
    w.pad_levels = pads;
    pending_words.push_back(w);
  endtask

  // Driver: offer the next pending word, predict each word as it is accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_outs.push_back(apply_word(in_ch.data));
        words_in <= words_in + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_words.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct(words_in)) begin
          in_ch.data  <= pending_words.pop_front();
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long output hold, counted on its own: the controller fills up and stalls its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && words_in >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: compare every accepted result with the oldest prediction
  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_outs.size() == 0) begin
          report_mismatch("unexpected result, read_data", out_ch.data.read_data, 32'd0);
        end else begin
          want = expected_outs.pop_front();
          if (out_ch.data.read_data !== want.read_data)
            report_mismatch("read_data", out_ch.data.read_data, want.read_data);
          if (out_ch.data.drive_values !== want.drive_values)
            report_mismatch("drive_values", out_ch.data.drive_values, want.drive_values);
          if (out_ch.data.drive_enables !== want.drive_enables)
            report_mismatch("drive_enables", out_ch.data.drive_enables, want.drive_enables);
          if (out_ch.data.irq !== want.irq)
            report_mismatch("irq", {31'd0, out_ch.data.irq}, {31'd0, want.irq});
        end
      end
      out_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= rx_idle_pct(words_in));
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("gpio_controller_per_line_words_tb: errors");
      $finish;
    end
  end

  // Build one random word; most are well-formed line setups, edges, EOIs and status reads
  task automatic queue_random(ref logic [31:0] gen_pads);
    int          r;
    int          line;
    logic [7:0]  addr;
    logic [31:0] data;
    logic [31:0] pads;
    logic [7:0]  rd_addrs [7];
    rd_addrs = '{ADDR_MODE, ADDR_STATUS_S, ADDR_RAW_S, ADDR_PORT,
                 ADDR_STATUS_NS, ADDR_RAW_NS, 8'h00};
    r    = $urandom_range(0, 99);
    line = $urandom_range(0, TB_LINES - 1);
    data = $urandom();
    pads = $urandom();
    addr = 8'((line + 1) * 4) | 8'($urandom_range(0, 3));
    if (r < 35) begin
      // Tick: mostly a few toggled pads so edges stay sparse, sometimes noise
      if ($urandom_range(0, 4) != 0) pads = gen_pads ^ ($urandom() & $urandom() & $urandom());
      gen_pads = pads;
      queue_word(OP_TICK, 8'($urandom()), data, pads);
    end else if (r < 65) begin
      if ($urandom_range(0, 9) < 8) begin
        // Line setup, interrupts enabled more often than not
        if ($urandom_range(0, 1) != 0) data[B_IEN] = 1'b1;
        if ($urandom_range(0, 2) == 0) data[B_MASK] = 1'b0;
        queue_word(OP_WRITE, addr, data, pads);
      end else if ($urandom_range(0, 1) != 0) begin
        // Mode word: zero half the time so both status views get used
        queue_word(OP_WRITE, ADDR_MODE | 8'($urandom_range(0, 3)),
                   ($urandom_range(0, 1) != 0) ? 32'd0 : data, pads);
      end else begin
        queue_word(OP_WRITE, 8'($urandom()), data, pads);
      end
    end else if (r < 95) begin
      case ($urandom_range(0, 2))
        0: addr = rd_addrs[$urandom_range(0, 5)] | 8'($urandom_range(0, 3));
        1: ;
        default: addr = 8'($urandom());
      endcase
      queue_word(OP_READ, addr, data, pads);
    end else begin
      queue_word(OP_NONE, 8'($urandom()), data, pads);
    end
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_ch.valid || expected_outs.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    logic [31:0] gen_pads;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    impl_lines   = (TB_LINES >= 32) ? 32'hffff_ffff : ((32'd1 << TB_LINES) - 32'd1);
    for (int n = 0; n < TB_LINES; n++) line_ctl[n] = '0;
    last_pads  = '0;
    edge_latch = '0;
    mode_word  = '0;
    gen_pads   = '0;

    // Directed words: reset values, every control bit, edge/level/both, views, EOI
    queue_word(OP_READ,  ADDR_MODE, 32'h0, 32'h0);
    queue_word(OP_READ,  8'h04, 32'hffff_ffff, 32'hffff_ffff);
    queue_word(OP_WRITE, 8'h04, 32'hffff_ffff, 32'h0);         // all bits, EOI reads back 0
    queue_word(OP_READ,  8'h04, 32'h0, 32'h0);
    queue_word(OP_WRITE, 8'h80, 32'h0000_0068, 32'h0);         // line 31: rising edge
    queue_word(OP_TICK,  8'h00, 32'h0, 32'h8000_0000);
    queue_word(OP_READ,  ADDR_STATUS_NS, 32'h0, 32'h0);
    queue_word(OP_READ,  ADDR_STATUS_S, 32'h0, 32'h0);         // hidden view reads zero
    queue_word(OP_WRITE, ADDR_MODE, 32'hffff_ffff, 32'h0);     // switch to secure view
    queue_word(OP_READ,  ADDR_STATUS_S, 32'h0, 32'h0);
    queue_word(OP_READ,  ADDR_RAW_NS, 32'h0, 32'h0);
    queue_word(OP_WRITE, 8'h83, 32'h0000_0168, 32'h0);         // unaligned, EOI on line 31
    queue_word(OP_READ,  ADDR_RAW_S, 32'h0, 32'h0);
    queue_word(OP_WRITE, 8'h0a, 32'h0000_0008, 32'h0);         // line 1: active-low level
    queue_word(OP_TICK,  8'hff, 32'hffff_ffff, 32'hffff_ffff); // every pad high; all but pad 31 rise
    queue_word(OP_READ,  ADDR_RAW_S | 8'h3, 32'h0, 32'h0);
    queue_word(OP_TICK,  8'h00, 32'h0, 32'h0);                 // every pad falls
    queue_word(OP_READ,  ADDR_PORT, 32'h0, 32'h0);
    queue_word(OP_WRITE, ADDR_PORT, 32'h1234_5678, 32'h0);     // read-only, ignored
    queue_word(OP_READ,  ADDR_PORT, 32'h0, 32'h0);
    queue_word(OP_WRITE, ADDR_MODE, 32'h0, 32'h0);
    queue_word(OP_READ,  ADDR_RAW_NS, 32'h0, 32'h0);
    queue_word(OP_WRITE, 8'hd0, 32'hffff_ffff, 32'hffff_ffff); // unlisted offset
    queue_word(OP_READ,  8'hff, 32'h0, 32'h0);                 // unlisted offset reads zero
    queue_word(OP_NONE,  ADDR_MODE, 32'hffff_ffff, 32'hffff_ffff);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Pause the sender until the directed part has fully drained
    @(negedge clk);
    wait_drained();

    for (int i = 0; i < 375; i++) queue_random(gen_pads);
    wait_drained();
    for (int i = 0; i < 375; i++) queue_random(gen_pads);
    wait_drained();

    // Let a stray late word show up before deciding
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("gpio_controller_per_line_words_tb: clean");
    end else begin
      $display("gpio_controller_per_line_words_tb: errors");
    end
    $finish;
  end

endmodule
